// ===== hdl/ipt_pkg.sv =====
`timescale 1ns / 1ps

package ipt_pkg;

  // field widths
  localparam int unsigned TIME_W   = 40;
  localparam int unsigned PHASE_W  = 48;
  localparam int unsigned COEF_W   = 32;
  localparam int unsigned ORDER_W  = 3;
  localparam int unsigned STATUS_W = 2;

  // configuration port
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  // fixed-point formats
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned ROOT_FRAC     = 32;
  localparam int unsigned COEF_FRAC     = 24;
  localparam int unsigned SPLIT_W       = 24;
  localparam int unsigned DIV_W         = 32;

  // term selection thresholds
  localparam logic [ORDER_W-1:0] ORD_TERM_TWO   = 3'd2;
  localparam logic [ORDER_W-1:0] ORD_TERM_THREE = 3'd3;
  localparam logic [ORDER_W-1:0] ORD_TERM_FOUR  = 3'd4;

  // reset values
  localparam logic [ORDER_W-1:0] ORDER_RST = 3'd4;
  localparam logic [COEF_W-1:0]  MASS_RST  = 32'h2000_0000;

  // saturation limits
  localparam logic [PHASE_W-1:0] PHASE_POS_LIM = {1'b0, {(PHASE_W-1){1'b1}}};
  localparam logic [PHASE_W-1:0] PHASE_NEG_LIM = {1'b1, {(PHASE_W-1){1'b0}}};

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_TIME_BAD = 2'd1,
    ST_SAT      = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    REG_ORDER      = 3'd0,
    REG_COEF_TWO   = 3'd1,
    REG_COEF_THREE = 3'd2,
    REG_COEF_FOUR  = 3'd3,
    REG_MASS       = 3'd4
  } reg_idx_e;

endpackage

// ===== hdl/inspiral_pn_time_phase_top.sv =====
// post-newtonian inspiral phase of time, fully pipelined
// input: time_var_i (unsigned, FRAC_BITS fraction bits) is taken at a clock edge
//   where start is high and busy is low; busy never rises, so one beat can
//   enter on every cycle
// output: done_o is high for exactly one cycle with phase_o and
//   result_status_o; the receiver cannot stall, results leave in input order
// pipeline: input register, three square root rows, stages m1 to m7, division
//   row and output register; throughput one beat per cycle, set by the
//   rows of square root cells (one per root bit) and the row of 48 division
//   cells, each cell passing its partial result to its neighbour every cycle
// configuration: apb port, registers at 4*i (order, three coefficients,
//   half mass ratio); write only while no beat is in flight; pready tied high
// reset: clears all valid flags and loads the register reset values; no beat
//   in flight survives it
// status: 0 ok, 1 time zero (phase 0), 2 phase saturated
`timescale 1ns / 1ps

module inspiral_pn_time_phase_top #(
  parameter int unsigned FRAC_BITS = ipt_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [ipt_pkg::TIME_W-1:0]    time_var_i,
  output logic                          done_o,
  output logic [ipt_pkg::PHASE_W-1:0]   phase_o,
  output logic [ipt_pkg::STATUS_W-1:0]  result_status_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ipt_pkg::ADDR_W-1:0]    paddr,
  input  logic [ipt_pkg::DATA_W-1:0]    pwdata,
  output logic [ipt_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  localparam int unsigned TW   = ipt_pkg::TIME_W;
  localparam int unsigned QW   = ipt_pkg::PHASE_W;
  localparam int unsigned CW   = ipt_pkg::COEF_W;
  localparam int unsigned OW   = ipt_pkg::ORDER_W;
  localparam int unsigned DW   = ipt_pkg::DIV_W;
  localparam int unsigned RF   = ipt_pkg::ROOT_FRAC;
  localparam int unsigned KF   = ipt_pkg::COEF_FRAC;
  localparam int unsigned LO   = ipt_pkg::SPLIT_W;

  // root widths: td^(1/2), td^(1/4), td^(1/8), all with 32 fraction bits
  localparam int unsigned RAD1_W = TW + 64 - FRAC_BITS;
  localparam int unsigned N1     = (RAD1_W + 1) / 2;
  localparam int unsigned N2     = (N1 + RF + 1) / 2;
  localparam int unsigned N3     = (N2 + RF + 1) / 2;
  localparam int unsigned H1     = N1 - LO;
  localparam int unsigned H2     = N2 - LO;
  localparam int unsigned H3     = N3 - LO;

  // product and term widths
  localparam int unsigned P58_W = N1 + N3;
  localparam int unsigned T58_W = P58_W - RF;
  localparam int unsigned P38_W = N2 + N3;
  localparam int unsigned T38_W = P38_W - RF;
  localparam int unsigned T38H  = T38_W - LO;
  localparam int unsigned P3_W  = CW + N2;
  localparam int unsigned E3_W  = P3_W - KF;
  localparam int unsigned P4_W  = CW + N3;
  localparam int unsigned E4_W  = P4_W - KF;
  localparam int unsigned P2_W  = CW + T38_W;
  localparam int unsigned E2_W  = P2_W - KF;

  localparam int unsigned W_LL    = 2 * LO;
  localparam int unsigned W58_HL  = H1 + LO;
  localparam int unsigned W58_LH  = LO + H3;
  localparam int unsigned W58_HH  = H1 + H3;
  localparam int unsigned W38_HL  = H2 + LO;
  localparam int unsigned W38_LH  = LO + H3;
  localparam int unsigned W38_HH  = H2 + H3;
  localparam int unsigned W3_L    = CW + LO;
  localparam int unsigned W3_H    = CW + H2;
  localparam int unsigned W4_L    = CW + LO;
  localparam int unsigned W4_H    = CW + H3;
  localparam int unsigned W2_L    = CW + LO;
  localparam int unsigned W2_H    = CW + T38H;

  // signed sum width, with headroom for three additions
  localparam int unsigned MAX_A = (T58_W > E2_W) ? T58_W : E2_W;
  localparam int unsigned MAX_B = (E3_W > E4_W) ? E3_W : E4_W;
  localparam int unsigned SW    = ((MAX_A > MAX_B) ? MAX_A : MAX_B) + 3;

  // divider range check: quotient must stay below 2^48
  localparam int unsigned SH   = QW - FRAC_BITS;
  localparam int unsigned HI_W = SW - SH;
  localparam int unsigned CMPW = (HI_W > DW) ? HI_W : DW;

  localparam int unsigned SIDE1_W = 1;
  localparam int unsigned SIDE2_W = 1 + N1;
  localparam int unsigned SIDE3_W = 1 + N1 + N2;
  localparam int unsigned DSIDE_W = 4;

  localparam int unsigned LAT = 2 + N1 + N2 + N3 + 7 + QW;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  ipt_pkg::reg_idx_e cfg_idx;
  logic              cfg_we;
  logic [OW-1:0]     order_d, order_q;
  logic [CW-1:0]     coef2_d, coef2_q;
  logic [CW-1:0]     coef3_d, coef3_q;
  logic [CW-1:0]     coef4_d, coef4_q;
  logic [CW-1:0]     mass_d, mass_q;

  assign cfg_idx = ipt_pkg::reg_idx_e'(paddr[ipt_pkg::ADDR_W-1:2]);
  assign cfg_we  = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign busy    = 1'b0;

  always_comb begin
    order_d = order_q;
    coef2_d = coef2_q;
    coef3_d = coef3_q;
    coef4_d = coef4_q;
    mass_d  = mass_q;
    if (cfg_we) begin
      case (cfg_idx)
        ipt_pkg::REG_ORDER:      order_d = pwdata[OW-1:0];
        ipt_pkg::REG_COEF_TWO:   coef2_d = pwdata;
        ipt_pkg::REG_COEF_THREE: coef3_d = pwdata;
        ipt_pkg::REG_COEF_FOUR:  coef4_d = pwdata;
        ipt_pkg::REG_MASS:       mass_d  = pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= ipt_pkg::ORDER_RST;
      coef2_q <= '0;
      coef3_q <= '0;
      coef4_q <= '0;
      mass_q  <= ipt_pkg::MASS_RST;
    end else begin
      order_q <= order_d;
      coef2_q <= coef2_d;
      coef3_q <= coef3_d;
      coef4_q <= coef4_d;
      mass_q  <= mass_d;
    end
  end

  always_comb begin
    case (cfg_idx)
      ipt_pkg::REG_ORDER:      prdata = ipt_pkg::DATA_W'(order_q);
      ipt_pkg::REG_COEF_TWO:   prdata = coef2_q;
      ipt_pkg::REG_COEF_THREE: prdata = coef3_q;
      ipt_pkg::REG_COEF_FOUR:  prdata = coef4_q;
      ipt_pkg::REG_MASS:       prdata = mass_q;
      default:                 prdata = '0;
    endcase
  end

  // coefficient magnitudes, refreshed every cycle (user keeps config quiet in flight; not enforced)
  logic [CW-1:0] c2mag_d, c2mag_q;
  logic [CW-1:0] c3mag_d, c3mag_q;
  logic [CW-1:0] c4mag_d, c4mag_q;

  assign c2mag_d = coef2_q[CW-1] ? (~coef2_q + 1'b1) : coef2_q;
  assign c3mag_d = coef3_q[CW-1] ? (~coef3_q + 1'b1) : coef3_q;
  assign c4mag_d = coef4_q[CW-1] ? (~coef4_q + 1'b1) : coef4_q;

  always_ff @(posedge clk_i) begin
    c2mag_q <= c2mag_d;
    c3mag_q <= c3mag_d;
    c4mag_q <= c4mag_d;
  end

  // ---------------------------------------------------------------------------
  // input stage and three square root rows
  // ---------------------------------------------------------------------------
  logic              v0_q;
  logic              tz0_q;
  logic [2*N1-1:0]   rad0_q;
  logic [2*N1-1:0]   rad0_d;

  assign rad0_d = (2*N1)'({time_var_i, {(64-FRAC_BITS){1'b0}}});

  always_ff @(posedge clk_i) begin
    rad0_q <= rad0_d;
    tz0_q  <= (time_var_i == '0);
  end

  logic               va;
  logic [N1-1:0]      r2_a;
  logic [SIDE1_W-1:0] side_a;

  ipt_sqrt_chain #(
    .RW(N1),
    .PW(SIDE1_W)
  ) u_root_two (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (v0_q),
    .rad_i  (rad0_q),
    .side_i (tz0_q),
    .vld_o  (va),
    .root_o (r2_a),
    .side_o (side_a)
  );

  logic               vb;
  logic [N2-1:0]      r4_b;
  logic [SIDE2_W-1:0] side_b;

  ipt_sqrt_chain #(
    .RW(N2),
    .PW(SIDE2_W)
  ) u_root_four (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (va),
    .rad_i  ((2*N2)'({r2_a, {RF{1'b0}}})),
    .side_i ({side_a, r2_a}),
    .vld_o  (vb),
    .root_o (r4_b),
    .side_o (side_b)
  );

  logic               vc;
  logic [N3-1:0]      r8_c;
  logic [SIDE3_W-1:0] side_c;

  ipt_sqrt_chain #(
    .RW(N3),
    .PW(SIDE3_W)
  ) u_root_eight (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (vb),
    .rad_i  ((2*N3)'({r4_b, {RF{1'b0}}})),
    .side_i ({side_b, r4_b}),
    .vld_o  (vc),
    .root_o (r8_c),
    .side_o (side_c)
  );

  logic          tz_c;
  logic [N1-1:0] r2_c;
  logic [N2-1:0] r4_c;

  assign {tz_c, r2_c, r4_c} = side_c;

  // ---------------------------------------------------------------------------
  // m1: partial products of the powers and of two coefficient terms
  // ---------------------------------------------------------------------------
  logic              v1_q, tz1_q;
  logic [W_LL-1:0]   pp58_ll_q;
  logic [W58_HL-1:0] pp58_hl_q;
  logic [W58_LH-1:0] pp58_lh_q;
  logic [W58_HH-1:0] pp58_hh_q;
  logic [W_LL-1:0]   pp38_ll_q;
  logic [W38_HL-1:0] pp38_hl_q;
  logic [W38_LH-1:0] pp38_lh_q;
  logic [W38_HH-1:0] pp38_hh_q;
  logic [W3_L-1:0]   pp3_l_q;
  logic [W3_H-1:0]   pp3_h_q;
  logic [W4_L-1:0]   pp4_l_q;
  logic [W4_H-1:0]   pp4_h_q;

  always_ff @(posedge clk_i) begin
    tz1_q     <= tz_c;
    pp58_ll_q <= W_LL'(r2_c[LO-1:0]) * W_LL'(r8_c[LO-1:0]);
    pp58_hl_q <= W58_HL'(r2_c[N1-1:LO]) * W58_HL'(r8_c[LO-1:0]);
    pp58_lh_q <= W58_LH'(r2_c[LO-1:0]) * W58_LH'(r8_c[N3-1:LO]);
    pp58_hh_q <= W58_HH'(r2_c[N1-1:LO]) * W58_HH'(r8_c[N3-1:LO]);
    pp38_ll_q <= W_LL'(r4_c[LO-1:0]) * W_LL'(r8_c[LO-1:0]);
    pp38_hl_q <= W38_HL'(r4_c[N2-1:LO]) * W38_HL'(r8_c[LO-1:0]);
    pp38_lh_q <= W38_LH'(r4_c[LO-1:0]) * W38_LH'(r8_c[N3-1:LO]);
    pp38_hh_q <= W38_HH'(r4_c[N2-1:LO]) * W38_HH'(r8_c[N3-1:LO]);
    pp3_l_q   <= W3_L'(c3mag_q) * W3_L'(r4_c[LO-1:0]);
    pp3_h_q   <= W3_H'(c3mag_q) * W3_H'(r4_c[N2-1:LO]);
    pp4_l_q   <= W4_L'(c4mag_q) * W4_L'(r8_c[LO-1:0]);
    pp4_h_q   <= W4_H'(c4mag_q) * W4_H'(r8_c[N3-1:LO]);
  end

  // ---------------------------------------------------------------------------
  // m2: td^(5/8), td^(3/8), a3 and a4 term magnitudes
  // ---------------------------------------------------------------------------
  logic [P58_W-1:0] p58;
  logic [P38_W-1:0] p38;
  logic [P3_W-1:0]  p3;
  logic [P4_W-1:0]  p4;
  logic             v2_q, tz2_q;
  logic [T58_W-1:0] t58_2_q;
  logic [T38_W-1:0] t38_2_q;
  logic [E3_W-1:0]  e3_2_q;
  logic [E4_W-1:0]  e4_2_q;

  assign p58 = (P58_W'(pp58_hh_q) << (2*LO)) + (P58_W'(pp58_hl_q) << LO)
             + (P58_W'(pp58_lh_q) << LO) + P58_W'(pp58_ll_q);
  assign p38 = (P38_W'(pp38_hh_q) << (2*LO)) + (P38_W'(pp38_hl_q) << LO)
             + (P38_W'(pp38_lh_q) << LO) + P38_W'(pp38_ll_q);
  assign p3  = (P3_W'(pp3_h_q) << LO) + P3_W'(pp3_l_q);
  assign p4  = (P4_W'(pp4_h_q) << LO) + P4_W'(pp4_l_q);

  always_ff @(posedge clk_i) begin
    tz2_q   <= tz1_q;
    t58_2_q <= p58[P58_W-1:RF];
    t38_2_q <= p38[P38_W-1:RF];
    e3_2_q  <= p3[P3_W-1:KF];
    e4_2_q  <= p4[P4_W-1:KF];
  end

  // ---------------------------------------------------------------------------
  // m3/m4: a2 term from td^(3/8)
  // ---------------------------------------------------------------------------
  logic             v3_q, tz3_q;
  logic [T58_W-1:0] t58_3_q;
  logic [E3_W-1:0]  e3_3_q;
  logic [E4_W-1:0]  e4_3_q;
  logic [W2_L-1:0]  pp2_l_q;
  logic [W2_H-1:0]  pp2_h_q;
  logic [P2_W-1:0]  p2;
  logic             v4_q, tz4_q;
  logic [T58_W-1:0] t58_4_q;
  logic [E2_W-1:0]  e2_4_q;
  logic [E3_W-1:0]  e3_4_q;
  logic [E4_W-1:0]  e4_4_q;

  assign p2 = (P2_W'(pp2_h_q) << LO) + P2_W'(pp2_l_q);

  always_ff @(posedge clk_i) begin
    tz3_q   <= tz2_q;
    t58_3_q <= t58_2_q;
    e3_3_q  <= e3_2_q;
    e4_3_q  <= e4_2_q;
    pp2_l_q <= W2_L'(c2mag_q) * W2_L'(t38_2_q[LO-1:0]);
    pp2_h_q <= W2_H'(c2mag_q) * W2_H'(t38_2_q[T38_W-1:LO]);
    tz4_q   <= tz3_q;
    t58_4_q <= t58_3_q;
    e2_4_q  <= p2[P2_W-1:KF];
    e3_4_q  <= e3_3_q;
    e4_4_q  <= e4_3_q;
  end

  // ---------------------------------------------------------------------------
  // m5: signed sum of the selected terms, two's complement in SW bits
  // ---------------------------------------------------------------------------
  logic [SW-1:0] x2, x3, x4, a2, a3, a4, s5_d;
  logic          v5_q, tz5_q;
  logic [SW-1:0] s5_q;

  assign x2 = SW'(e2_4_q);
  assign x3 = SW'(e3_4_q);
  assign x4 = SW'(e4_4_q);

  always_comb begin
    a2 = '0;
    a3 = '0;
    a4 = '0;
    // orders above four behave as four
    if (order_q >= ipt_pkg::ORD_TERM_TWO) begin
      a2 = coef2_q[CW-1] ? (~x2 + 1'b1) : x2;
    end
    if (order_q >= ipt_pkg::ORD_TERM_THREE) begin
      a3 = coef3_q[CW-1] ? x3 : (~x3 + 1'b1);
    end
    if (order_q >= ipt_pkg::ORD_TERM_FOUR) begin
      a4 = coef4_q[CW-1] ? (~x4 + 1'b1) : x4;
    end
    s5_d = SW'(t58_4_q) + a2 + a3 + a4;
  end

  always_ff @(posedge clk_i) begin
    tz5_q <= tz4_q;
    s5_q  <= s5_d;
  end

  // ---------------------------------------------------------------------------
  // m6: sign and magnitude; phase sign is that of -S
  // ---------------------------------------------------------------------------
  logic          v6_q, tz6_q, neg6_q, sz6_q;
  logic [SW-1:0] mag6_q;

  always_ff @(posedge clk_i) begin
    tz6_q  <= tz5_q;
    neg6_q <= ~s5_q[SW-1];
    sz6_q  <= (s5_q == '0);
    mag6_q <= s5_q[SW-1] ? (~s5_q + 1'b1) : s5_q;
  end

  // ---------------------------------------------------------------------------
  // m7: divider set-up; overflow if the top dividend bits reach the divisor
  // (also covers a zero divisor)
  // ---------------------------------------------------------------------------
  logic [HI_W-1:0]    hi6;
  logic               v7_q;
  logic [DW-1:0]      rem7_q;
  logic [QW-1:0]      num7_q;
  logic [DSIDE_W-1:0] side7_q;

  assign hi6 = mag6_q[SW-1:SH];

  always_ff @(posedge clk_i) begin
    rem7_q  <= DW'(hi6);
    num7_q  <= {mag6_q[SH-1:0], {FRAC_BITS{1'b0}}};
    side7_q <= {neg6_q, ~(CMPW'(hi6) < CMPW'(mass_q)), sz6_q, tz6_q};
  end

  // ---------------------------------------------------------------------------
  // division row: 48 quotient bits, one per cell
  // ---------------------------------------------------------------------------
  logic               dv    [0:QW];
  logic [DW-1:0]      drem  [0:QW];
  logic [QW-1:0]      dnum  [0:QW];
  logic [QW-1:0]      dquo  [0:QW];
  logic [DSIDE_W-1:0] dside [0:QW];

  assign dv[0]    = v7_q;
  assign drem[0]  = rem7_q;
  assign dnum[0]  = num7_q;
  assign dquo[0]  = '0;
  assign dside[0] = side7_q;

  for (genvar k = 0; k < QW; k++) begin : g_div
    ipt_div_cell #(
      .PW(DSIDE_W)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (dv[k]),
      .rem_i  (drem[k]),
      .num_i  (dnum[k]),
      .quo_i  (dquo[k]),
      .side_i (dside[k]),
      .den_i  (mass_q),
      .vld_o  (dv[k+1]),
      .rem_o  (drem[k+1]),
      .num_o  (dnum[k+1]),
      .quo_o  (dquo[k+1]),
      .side_o (dside[k+1])
    );
  end

  // ---------------------------------------------------------------------------
  // output stage: saturation, sign and special cases
  // ---------------------------------------------------------------------------
  logic              f_neg, f_ovf, f_sz, f_tz, f_sat;
  logic [QW-1:0]     quo;
  logic [QW-1:0]     phase_d, phase_q;
  ipt_pkg::status_e  status_d, status_q;
  logic              done_q;

  assign quo = dquo[QW];
  assign {f_neg, f_ovf, f_sz, f_tz} = dside[QW];
  assign f_sat = f_ovf | (f_neg ? (quo[QW-1] & (|quo[QW-2:0])) : quo[QW-1]);

  always_comb begin
    if (f_tz) begin
      phase_d  = '0;
      status_d = ipt_pkg::ST_TIME_BAD;
    end else if (f_sz) begin
      phase_d  = '0;
      status_d = ipt_pkg::ST_OK;
    end else if (f_sat) begin
      phase_d  = f_neg ? ipt_pkg::PHASE_NEG_LIM : ipt_pkg::PHASE_POS_LIM;
      status_d = ipt_pkg::ST_SAT;
    end else begin
      phase_d  = f_neg ? (~quo + 1'b1) : quo;
      status_d = ipt_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    phase_q  <= phase_d;
    status_q <= status_d;
  end

  // valid flags of the stages outside the cell rows
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q   <= 1'b0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
      v6_q   <= 1'b0;
      v7_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v0_q   <= start && !busy;
      v1_q   <= vc;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      v5_q   <= v4_q;
      v6_q   <= v5_q;
      v7_q   <= v6_q;
      done_q <= dv[QW];
    end
  end

  assign done_o          = done_q;
  assign phase_o         = phase_q;
  assign result_status_o = status_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_fixed_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LAT))
    else $error("result beat without a matching input beat");

  a_time_zero_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (result_status_o == ipt_pkg::ST_TIME_BAD)) |-> (phase_o == '0))
    else $error("zero time beat with non-zero phase");

  a_sat_at_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (result_status_o == ipt_pkg::ST_SAT)) |->
      ((phase_o == ipt_pkg::PHASE_POS_LIM) || (phase_o == ipt_pkg::PHASE_NEG_LIM)))
    else $error("saturated beat not at a phase limit");

endmodule

// ===== hdl/ipt_sqrt_cell.sv =====
`timescale 1ns / 1ps

// one restoring square root step: two radicand bits in, one root bit out
module ipt_sqrt_cell #(
  parameter int unsigned RW = 8,
  parameter int unsigned PW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            vld_i,
  input  logic [2*RW-1:0] rad_i,
  input  logic [RW+1:0]   rem_i,
  input  logic [RW-1:0]   root_i,
  input  logic [PW-1:0]   side_i,
  output logic            vld_o,
  output logic [2*RW-1:0] rad_o,
  output logic [RW+1:0]   rem_o,
  output logic [RW-1:0]   root_o,
  output logic [PW-1:0]   side_o
);

  logic [RW+1:0]   cur;
  logic [RW+1:0]   trial;
  logic            ge;
  logic            vld_q;
  logic [2*RW-1:0] rad_d, rad_q;
  logic [RW+1:0]   rem_d, rem_q;
  logic [RW-1:0]   root_d, root_q;
  logic [PW-1:0]   side_q;

  // incoming remainder and root are always short of their last bit
  assign cur    = {rem_i[RW-1:0], rad_i[2*RW-1 -: 2]};
  assign trial  = {1'b0, root_i[RW-2:0], 2'b01};
  assign ge     = cur >= trial;
  assign rem_d  = ge ? (cur - trial) : cur;
  assign root_d = {root_i[RW-2:0], ge};
  assign rad_d  = rad_i << 2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    side_q <= side_i;
  end

  assign vld_o  = vld_q;
  assign rad_o  = rad_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign side_o = side_q;

endmodule

// ===== hdl/ipt_sqrt_chain.sv =====
`timescale 1ns / 1ps

// floor square root, one cell per root bit
module ipt_sqrt_chain #(
  parameter int unsigned RW = 8,
  parameter int unsigned PW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            vld_i,
  input  logic [2*RW-1:0] rad_i,
  input  logic [PW-1:0]   side_i,
  output logic            vld_o,
  output logic [RW-1:0]   root_o,
  output logic [PW-1:0]   side_o
);

  logic            vld  [0:RW];
  logic [2*RW-1:0] rad  [0:RW];
  logic [RW+1:0]   rem  [0:RW];
  logic [RW-1:0]   root [0:RW];
  logic [PW-1:0]   side [0:RW];

  assign vld[0]  = vld_i;
  assign rad[0]  = rad_i;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign side[0] = side_i;

  for (genvar k = 0; k < RW; k++) begin : g_cell
    ipt_sqrt_cell #(
      .RW(RW),
      .PW(PW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (vld[k]),
      .rad_i  (rad[k]),
      .rem_i  (rem[k]),
      .root_i (root[k]),
      .side_i (side[k]),
      .vld_o  (vld[k+1]),
      .rad_o  (rad[k+1]),
      .rem_o  (rem[k+1]),
      .root_o (root[k+1]),
      .side_o (side[k+1])
    );
  end

  assign vld_o  = vld[RW];
  assign root_o = root[RW];
  assign side_o = side[RW];

endmodule

// ===== hdl/ipt_div_cell.sv =====
`timescale 1ns / 1ps

// one restoring division step: one dividend bit in, one quotient bit out
module ipt_div_cell #(
  parameter int unsigned PW = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       vld_i,
  input  logic [ipt_pkg::DIV_W-1:0]  rem_i,
  input  logic [ipt_pkg::PHASE_W-1:0] num_i,
  input  logic [ipt_pkg::PHASE_W-1:0] quo_i,
  input  logic [PW-1:0]              side_i,
  input  logic [ipt_pkg::DIV_W-1:0]  den_i,
  output logic                       vld_o,
  output logic [ipt_pkg::DIV_W-1:0]  rem_o,
  output logic [ipt_pkg::PHASE_W-1:0] num_o,
  output logic [ipt_pkg::PHASE_W-1:0] quo_o,
  output logic [PW-1:0]              side_o
);

  localparam int unsigned DW = ipt_pkg::DIV_W;
  localparam int unsigned QW = ipt_pkg::PHASE_W;

  logic [DW:0]   cur;
  logic [DW:0]   diff;
  logic          ge;
  logic          vld_q;
  logic [DW-1:0] rem_d, rem_q;
  logic [QW-1:0] num_d, num_q;
  logic [QW-1:0] quo_d, quo_q;
  logic [PW-1:0] side_q;

  assign cur   = {rem_i, num_i[QW-1]};
  assign diff  = cur - {1'b0, den_i};
  assign ge    = cur >= {1'b0, den_i};
  assign rem_d = ge ? diff[DW-1:0] : cur[DW-1:0];
  assign num_d = num_i << 1;
  assign quo_d = {quo_i[QW-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    num_q  <= num_d;
    quo_q  <= quo_d;
    side_q <= side_i;
  end

  assign vld_o  = vld_q;
  assign rem_o  = rem_q;
  assign num_o  = num_q;
  assign quo_o  = quo_q;
  assign side_o = side_q;

endmodule

// ===== test/inspiral_pn_time_phase_checker.sv =====
`timescale 1ns / 1ps

module inspiral_pn_time_phase_checker #(
  parameter int unsigned FRAC_BITS = ipt_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  input  logic                                  busy,
  input  logic [ipt_pkg::TIME_W-1:0]            time_var_i,
  input  logic                                  done_o,
  input  logic [ipt_pkg::PHASE_W-1:0]           phase_o,
  input  logic [ipt_pkg::STATUS_W-1:0]          result_status_o,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [ipt_pkg::ADDR_W-1:0]            paddr,
  input  logic [ipt_pkg::DATA_W-1:0]            pwdata,
  input  logic                                  pready,
  output int                                    fail_count_o,
  output int                                    pending_o,
  output int                                    phase_count_o
);
  import ipt_pkg::*;

  typedef struct packed {
    logic [PHASE_W-1:0]  phase;
    logic [STATUS_W-1:0] status;
  } phase_beat_t;

  phase_beat_t expected_phases[$];

  logic [ORDER_W-1:0] order_q;
  logic [COEF_W-1:0]  coef_two_q, coef_three_q, coef_four_q, mass_q;

  function automatic logic [63:0] isqrt128(logic [127:0] v);
    logic [63:0]  r;
    logic [63:0]  c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= v) r = c;
    end
    return r;
  endfunction

  function automatic logic signed [63:0] coef_mul(logic [31:0] raw, logic [63:0] pw);
    logic [63:0]  mag;
    logic [127:0] p;
    mag = raw[31] ? (64'd1 << 32) - {32'd0, raw} : {32'd0, raw};
    p = ({64'd0, mag} * {64'd0, pw}) >> COEF_FRAC;
    return raw[31] ? -$signed(p[63:0]) : $signed(p[63:0]);
  endfunction

  function automatic phase_beat_t predict_phase(logic [TIME_W-1:0] td);
    phase_beat_t        res;
    logic [63:0]        r2, r4, r8, mag, lim, q;
    logic [127:0]       w;
    logic signed [63:0] s;
    logic [2:0]         ord;
    logic               neg, sat;
    if (td == 0) begin
      res.phase = '0;
      res.status = ST_TIME_BAD;
      return res;
    end
    r2 = isqrt128({88'd0, td} << (64 - FRAC_BITS));
    r4 = isqrt128({64'd0, r2} << 32);
    r8 = isqrt128({64'd0, r4} << 32);
    ord = (order_q > 4) ? 3'd4 : order_q;
    w = ({64'd0, r2} * {64'd0, r8}) >> 32;
    s = w[63:0];
    if (ord >= ORD_TERM_TWO) begin
      w = ({64'd0, r4} * {64'd0, r8}) >> 32;
      s = s + coef_mul(coef_two_q, w[63:0]);
    end
    if (ord >= ORD_TERM_THREE) s = s - coef_mul(coef_three_q, r4);
    if (ord >= ORD_TERM_FOUR) s = s + coef_mul(coef_four_q, r8);
    if (s == 0) begin
      res.phase = '0;
      res.status = ST_OK;
      return res;
    end
    neg = s > 0;
    mag = neg ? s : -s;
    lim = neg ? 64'd1 << 47 : (64'd1 << 47) - 1;
    sat = 1'b0;
    if (mass_q == 0) begin
      sat = 1'b1;
      q = lim;
    end else begin
      // quotient with FRAC_BITS extra fraction bits, truncated
      w = ({64'd0, mag} << FRAC_BITS) / {96'd0, mass_q};
      if (w > {64'd0, lim}) begin
        sat = 1'b1;
        q = lim;
      end else begin
        q = w[63:0];
      end
    end
    q = neg ? -q : q;
    res.phase = q[PHASE_W-1:0];
    res.status = sat ? ST_SAT : ST_OK;
    return res;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    phase_beat_t exp_b;
    if (!rst_ni) begin
      order_q <= ORDER_RST;
      coef_two_q <= '0;
      coef_three_q <= '0;
      coef_four_q <= '0;
      mass_q <= MASS_RST;
      fail_count_o <= 0;
      phase_count_o <= 0;
      expected_phases.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_ORDER:      order_q <= pwdata[ORDER_W-1:0];
          REG_COEF_TWO:   coef_two_q <= pwdata;
          REG_COEF_THREE: coef_three_q <= pwdata;
          REG_COEF_FOUR:  coef_four_q <= pwdata;
          REG_MASS:       mass_q <= pwdata;
          default: ;
        endcase
      end
      if (start && !busy) expected_phases.push_back(predict_phase(time_var_i));
      if (done_o) begin
        phase_count_o <= phase_count_o + 1;
        if (expected_phases.size() == 0) begin
          $display("%0t: unexpected phase beat %h status %0d", $time, phase_o,
                   result_status_o);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_b = expected_phases.pop_front();
          if (exp_b.phase !== phase_o || exp_b.status !== result_status_o) begin
            $display("%0t: phase mismatch, expected %h/%0d actual %h/%0d", $time,
                     exp_b.phase, exp_b.status, phase_o, result_status_o);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

  assign pending_o = expected_phases.size();

endmodule

// ===== test/inspiral_pn_time_phase_top_test.sv =====
`timescale 1ns / 1ps

module inspiral_pn_time_phase_top_test;
  import ipt_pkg::*;

  localparam int LAT = 174;
  localparam longint CYCLE_LIMIT = 400000;

  logic                clk_i, rst_ni;
  logic                start, busy;
  logic [TIME_W-1:0]   time_var_i;
  logic                done_o;
  logic [PHASE_W-1:0]  phase_o;
  logic [STATUS_W-1:0] result_status_o;
  logic                psel, penable, pwrite, pready;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata, prdata;
  int                  fail_count, pending, phase_count;
  int                  idle_pct;
  longint              cycle_count;
  int                  beats_sent;

  inspiral_pn_time_phase_top dut (.*);

  inspiral_pn_time_phase_checker checker_i (
    .clk_i, .rst_ni, .start, .busy, .time_var_i, .done_o, .phase_o,
    .result_status_o, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count_o(fail_count), .pending_o(pending), .phase_count_o(phase_count)
  );

  // free-running clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // watchdog, well beyond the slowest correct run
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("inspiral_pn_time_phase_top_test NOT OK");
        $finish;
      end
    end
  end

  // apb write: setup then access, pready is tied high
  task automatic reg_write(reg_idx_e idx, logic [DATA_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // wait until the pipeline is empty, then the latency over again
  task automatic drain_pipe();
    while (pending != 0) @(posedge clk_i);
    repeat (LAT + 4) @(posedge clk_i);
  endtask

  task automatic load_model(logic [2:0] ord, logic [31:0] a2, logic [31:0] a3,
                            logic [31:0] a4, logic [31:0] eta);
    drain_pipe();
    reg_write(REG_ORDER, DATA_W'(ord));
    reg_write(REG_COEF_TWO, a2);
    reg_write(REG_COEF_THREE, a3);
    reg_write(REG_COEF_FOUR, a4);
    reg_write(REG_MASS, eta);
  endtask

  // one beat, with random sender gaps; start stays high across back-to-back beats
  task automatic send_time(logic [TIME_W-1:0] td);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start <= 1'b1;
    time_var_i <= td;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    beats_sent++;
  endtask

  // mostly moderate times, some full range, a few edge values
  function automatic logic [TIME_W-1:0] rand_time();
    logic [TIME_W-1:0] v;
    case ($urandom_range(9))
      0: v = TIME_W'({$urandom, $urandom});
      1: v = TIME_W'($urandom_range(3));
      2: v = {TIME_W{1'b1}} - TIME_W'($urandom_range(3));
      default: v = TIME_W'({$urandom, $urandom}) >> $urandom_range(39);
    endcase
    return v;
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      default: return $urandom >> $urandom_range(31);
    endcase
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      send_time(rand_time());
    end
    start <= 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    time_var_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    beats_sent = 0;
    idle_pct = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset settings, zero time, extremes of td
    send_time('0);
    send_time(TIME_W'(1));
    send_time(TIME_W'(1) << 16);
    send_time({TIME_W{1'b1}});
    send_time(40'h55_5555_5555);
    send_time(40'haa_aaaa_aaaa);
    start <= 1'b0;

    // every order, order above four, extreme coefficients, zero divisor
    for (int o = 0; o < 8; o++) begin
      load_model(o[2:0], 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'd1);
      send_time(TIME_W'(1) << 16);
      send_time({TIME_W{1'b1}});
      start <= 1'b0;
    end
    load_model(3'd4, '0, '0, '0, 32'd0);
    send_time(TIME_W'(1) << 20);
    start <= 1'b0;
    // cancelling terms give a zero sum: td = 1, a2 = -1, others zero
    load_model(3'd2, 32'hff00_0000, '0, '0, 32'd0);
    send_time(TIME_W'(1) << 16);
    send_time(TIME_W'(1) << 16);
    start <= 1'b0;
    load_model(3'd4, 32'h0100_0000, '0, '0, 32'hffff_ffff);
    send_time(TIME_W'(1) << 16);
    start <= 1'b0;

    // random part in three idling regimes, new settings per block
    for (int blk = 0; blk < 12; blk++) begin
      idle_pct = (blk < 4) ? 14 : (blk < 8) ? 47 : 0;
      load_model(3'($urandom_range(7)), rand_coef(), rand_coef(), rand_coef(),
                 ($urandom_range(9) == 0) ? 32'd0 :
                 ($urandom_range(3) == 0) ? 32'hffff_ffff : $urandom | 32'd1);
      random_phase(54);
      // hold off until every expected phase is back
      while (pending != 0) @(posedge clk_i);
      random_phase(54);
    end

    drain_pipe();
    $display("sent %0d time beats over all pn orders and coefficient extremes,",
             beats_sent);
    $display("checked %0d phase beats incl. zero time, zero sum and saturation",
             phase_count);
    if (fail_count == 0) begin
      $display("inspiral_pn_time_phase_top_test OK");
    end else begin
      $display("inspiral_pn_time_phase_top_test NOT OK");
    end
    $finish;
  end

endmodule
